// ----- design/ntde_pkg.sv -----
// ----------------------------------------------------------------------------
// ntde_pkg: shared types and constants for the node table
// Entry record, request and status codes, and table geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package ntde_pkg;
    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic REQ_PACKET  = 1'b0;
    localparam logic REQ_CLEANUP = 1'b1;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_OLD     = 3'd3;
    localparam logic [2:0] ST_REPLACE = 3'd4;
    localparam logic [2:0] ST_CLEANUP = 3'd5;

    localparam logic [31:0] MAX_AGE_RESET = 32'd1800000;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] seq;
        logic [7:0]  prio;
        logic [31:0] payload;
        logic [31:0] stamp;
    } entry_t;

    // Control from the sequencer to one cell.
    typedef struct packed {
        logic       shift;      // take the entry of the neighbor
        logic       write;      // take wr_entry
    } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- design/ntde_cell.sv -----
// ----------------------------------------------------------------------------
// ntde_cell: one storage cell of the node table ring
// Holds one entry and takes its neighbor's entry when told to shift.
// ----------------------------------------------------------------------------
`default_nettype none
module ntde_cell
    import ntde_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     wr_entry,
    input  wire entry_t     prev_entry,
    output entry_t          entry
);
    entry_t entry_reg;
    entry_t entry_next;

    // A write takes the new entry; otherwise the cell may shift.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write)
        begin
            entry_next = wr_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule
`default_nettype wire

// ----- design/node_table_dedup_evict.sv -----
// ----------------------------------------------------------------------------
// node_table_dedup_evict: node table with sequence dedup and eviction
// Ring of DEPTH cells scanned one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (in_valid/in_stall) carries one packet update or one
// cleanup request; the result channel (out_valid/out_stall) returns one
// result per request. max_age is written through cfg_we/cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it.
// The table is a ring of DEPTH cells. A request rotates the ring once through
// all DEPTH positions, one slot per cycle with slot p at the head in scan
// cycle p, then applies the write and loads the result in the apply state.
// A cleanup that marked entries then closes each gap in the compaction
// state, removing the marked slots from the highest down, before the result
// is valid. One request is handled at a time; in_stall is high from the
// request transfer until the result transfer, so no new request is taken
// before the last one is through. Reset clears the occupancy and the packet
// counter and sets max_age to 1800000; table contents are not cleared. A
// stalled result holds on the ports and the block takes no new request until
// it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module node_table_dedup_evict
    import ntde_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] node_id,
    input  wire logic [15:0] seq_num,
    input  wire logic [7:0]  priority_req,
    input  wire logic [31:0] payload,
    input  wire logic [31:0] now_time,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [2:0]       slot,
    output logic [15:0]      lost_count,
    output logic [15:0]      evicted_id,
    output logic [3:0]       removed_count,
    output logic [3:0]       active_count,
    output logic [31:0]      packets_total
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_APPLY   = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      max_age_reg;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [31:0]      total_reg, total_next;
    logic [IDX_W-1:0] pos_reg, pos_next;     // slot currently at the head
    // Request held during the scan.
    logic             rq_type_reg;
    entry_t           rq_reg;
    // Search results.
    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic [15:0]      hit_seq_reg, hit_seq_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [8:0]       best_pr_reg, best_pr_next;
    logic [31:0]      best_age_reg, best_age_next;
    logic [15:0]      best_id_reg, best_id_next;
    logic [DEPTH-1:0] dead_reg, dead_next;   // cleanup: slots to remove
    logic [CNT_W-1:0] rm_cnt_reg, rm_cnt_next;
    // Result register.
    logic [2:0]       status_reg, status_next;
    logic [2:0]       slot_reg, slot_next;
    logic [15:0]      lost_reg, lost_next;
    logic [15:0]      evicted_reg, evicted_next;
    logic [3:0]       removed_reg, removed_next;

    entry_t           cells [DEPTH];
    entry_t           wr_entry;
    entry_t           head;
    logic [31:0]      head_age;
    logic             head_occ;
    logic             in_xfer;
    logic             out_xfer;
    logic             scan_shift;
    logic             compact_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] top_dead;
    logic [DEPTH-1:0] shift_vec;             // per slot
    logic [DEPTH-1:0] write_vec;             // per slot

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    // Slot s lives in cell DEPTH-1-s, so slot 0 sits at the head of the ring.
    assign head     = cells[DEPTH-1];
    assign head_age = rq_reg.stamp - head.stamp;
    assign head_occ = (CNT_W'(pos_reg) < occ_reg);
    assign wr_entry = rq_reg;

    assign status        = status_reg;
    assign slot          = slot_reg;
    assign lost_count    = lost_reg;
    assign evicted_id    = evicted_reg;
    assign removed_count = removed_reg;
    assign active_count  = 4'(occ_reg);
    assign packets_total = total_reg;

    // Cell chain: cell k takes the entry of cell k-1; cell 0 takes the head.
    // Shifting every cell rotates the ring; shifting the cells of slot j and
    // above removes slot j and moves the later slots down by one.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t     prev_e;
            cell_ctrl_t c_ctrl;
            if (g == 0)
            begin : g_first
                assign prev_e = head;
            end
            else
            begin : g_rest
                assign prev_e = cells[g-1];
            end
            assign c_ctrl = '{shift: shift_vec[DEPTH-1-g], write: write_vec[DEPTH-1-g]};
            ntde_cell u_cell (
                .clk        (clk),
                .ctrl       (c_ctrl),
                .wr_entry   (wr_entry),
                .prev_entry (prev_e),
                .entry      (cells[g])
            );
        end
    endgenerate

    // Highest slot still marked for removal; compaction runs top down so
    // the lower marks keep their slot numbers.
    always_comb
    begin
        top_dead = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (dead_reg[i])
            begin
                top_dead = IDX_W'(i);
            end
        end
    end

    // Per-slot shift and write enables.
    always_comb
    begin
        for (int s = 0; s < DEPTH; s++)
        begin
            shift_vec[s] = scan_shift || (compact_en && (IDX_W'(s) >= top_dead));
            write_vec[s] = wr_en && (wr_slot == IDX_W'(s));
        end
    end

    // Sequencer: scan, apply, optional compaction, then hold the result.
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        occ_next      = occ_reg;
        total_next    = total_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        hit_seq_next  = hit_seq_reg;
        best_next     = best_reg;
        best_pr_next  = best_pr_reg;
        best_age_next = best_age_reg;
        best_id_next  = best_id_reg;
        dead_next     = dead_reg;
        rm_cnt_next   = rm_cnt_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        lost_next     = lost_reg;
        evicted_next  = evicted_reg;
        removed_next  = removed_reg;
        scan_shift    = 1'b0;
        compact_en    = 1'b0;
        wr_en         = 1'b0;
        wr_slot       = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next    = S_SCAN;
                    pos_next      = '0;
                    found_next    = 1'b0;
                    hit_next      = '0;
                    hit_seq_next  = '0;
                    best_next     = '0;
                    best_pr_next  = 9'd256;
                    best_age_next = '0;
                    best_id_next  = '0;
                    dead_next     = '0;
                    rm_cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                scan_shift = 1'b1;
                if (head_occ)
                begin
                    if (rq_type_reg == REQ_CLEANUP)
                    begin
                        if (head_age > max_age_reg)
                        begin
                            dead_next[pos_reg] = 1'b1;
                            rm_cnt_next = rm_cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // First matching id wins.
                        if (!found_reg && head.id == rq_reg.id)
                        begin
                            found_next   = 1'b1;
                            hit_next     = pos_reg;
                            hit_seq_next = head.seq;
                        end
                        // Lowest priority, then oldest, first slot on ties.
                        if ({1'b0, head.prio} < best_pr_reg ||
                            ({1'b0, head.prio} == best_pr_reg && head_age > best_age_reg))
                        begin
                            best_next     = pos_reg;
                            best_pr_next  = {1'b0, head.prio};
                            best_age_next = head_age;
                            best_id_next  = head.id;
                        end
                    end
                end
                pos_next = pos_reg + IDX_W'(1);
                if (pos_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                lost_next    = '0;
                evicted_next = '0;
                removed_next = '0;
                slot_next    = '0;
                state_next   = S_OUT;
                if (rq_type_reg == REQ_CLEANUP)
                begin
                    status_next  = ST_CLEANUP;
                    removed_next = 4'(rm_cnt_reg);
                    occ_next     = occ_reg - rm_cnt_reg;
                    if (dead_reg != '0)
                    begin
                        state_next = S_COMPACT;
                    end
                end
                else if (found_reg)
                begin
                    slot_next = 3'(hit_reg);
                    if (rq_reg.seq > hit_seq_reg)
                    begin
                        lost_next   = rq_reg.seq - hit_seq_reg - 16'd1;
                        wr_en       = 1'b1;
                        wr_slot     = hit_reg;
                        total_next  = total_reg + 32'd1;
                        status_next = ST_UPDATED;
                    end
                    else if (rq_reg.seq == hit_seq_reg)
                    begin
                        status_next = ST_DUP;
                    end
                    else
                    begin
                        status_next = ST_OLD;
                    end
                end
                else if (occ_reg < CNT_W'(DEPTH))
                begin
                    slot_next   = 3'(occ_reg);
                    wr_en       = 1'b1;
                    wr_slot     = IDX_W'(occ_reg);
                    occ_next    = occ_reg + CNT_W'(1);
                    total_next  = total_reg + 32'd1;
                    status_next = ST_NEW;
                end
                else
                begin
                    // Full table: the chosen slot takes the new entry.
                    slot_next    = 3'(best_reg);
                    evicted_next = best_id_reg;
                    wr_en        = 1'b1;
                    wr_slot      = best_reg;
                    status_next  = ST_REPLACE;
                end
            end
            S_COMPACT:
            begin
                // Remove one marked slot per cycle.
                compact_en = 1'b1;
                dead_next[top_dead] = 1'b0;
                if (dead_next == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            max_age_reg  <= MAX_AGE_RESET;
            occ_reg      <= '0;
            total_reg    <= '0;
            pos_reg      <= '0;
            rq_type_reg  <= REQ_PACKET;
            rq_reg       <= '0;
            found_reg    <= 1'b0;
            hit_reg      <= '0;
            hit_seq_reg  <= '0;
            best_reg     <= '0;
            best_pr_reg  <= '0;
            best_age_reg <= '0;
            best_id_reg  <= '0;
            dead_reg     <= '0;
            rm_cnt_reg   <= '0;
            status_reg   <= ST_NEW;
            slot_reg     <= '0;
            lost_reg     <= '0;
            evicted_reg  <= '0;
            removed_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_age_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                rq_type_reg <= req_type;
                rq_reg      <= '{node_id, seq_num, priority_req, payload, now_time};
            end
            occ_reg      <= occ_next;
            total_reg    <= total_next;
            pos_reg      <= pos_next;
            found_reg    <= found_next;
            hit_reg      <= hit_next;
            hit_seq_reg  <= hit_seq_next;
            best_reg     <= best_next;
            best_pr_reg  <= best_pr_next;
            best_age_reg <= best_age_next;
            best_id_reg  <= best_id_next;
            dead_reg     <= dead_next;
            rm_cnt_reg   <= rm_cnt_next;
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            lost_reg     <= lost_next;
            evicted_reg  <= evicted_next;
            removed_reg  <= removed_next;
        end
    end

`ifndef SYNTHESIS
    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
        $stable({status, slot, lost_count, evicted_id, removed_count,
                 active_count, packets_total}));
    // The occupancy never exceeds the table size.
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH));
    // After a request transfer the block is busy and has no result yet.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall && !out_valid);
    // Only defined status codes are presented.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_CLEANUP);
`endif
endmodule
`default_nettype wire

// ----- sim/node_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_table_checker: result predictor and scoreboard for the node table
// Watches the request, result and register ports, keeps its own copy of the
// table, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module node_table_checker
    import ntde_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] node_id,
    input  wire logic [15:0] seq_num,
    input  wire logic [7:0]  priority_req,
    input  wire logic [31:0] payload,
    input  wire logic [31:0] now_time,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  status,
    input  wire logic [2:0]  slot,
    input  wire logic [15:0] lost_count,
    input  wire logic [15:0] evicted_id,
    input  wire logic [3:0]  removed_count,
    input  wire logic [3:0]  active_count,
    input  wire logic [31:0] packets_total,
    output int               fail_count,
    output int               pending,
    output int               result_count
);
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [15:0] lost;
        logic [15:0] evicted;
        logic [3:0]  removed;
        logic [3:0]  active;
        logic [31:0] total;
    } verdict_t;

    entry_t      table_copy [DEPTH];
    int          used;
    logic [31:0] pkt_total;
    logic [31:0] age_limit;
    verdict_t    verdict_q [$];

    // Apply one request to the table copy and return its expected result.
    function automatic verdict_t apply_request(logic rt, logic [15:0] id, logic [15:0] sq,
                                               logic [7:0] pr, logic [31:0] pl,
                                               logic [31:0] now);
        verdict_t v;
        int kept;
        int hit;
        int best;
        int best_pr;
        logic [31:0] best_age;
        logic [31:0] age;
        v = '0;
        hit = -1;
        if (rt)
        begin
            kept = 0;
            for (int i = 0; i < used; i++)
            begin
                age = now - table_copy[i].stamp;
                if (age > age_limit)
                    v.removed++;
                else
                begin
                    table_copy[kept] = table_copy[i];
                    kept++;
                end
            end
            used = kept;
            v.status = ST_CLEANUP;
        end
        else
        begin
            for (int i = 0; i < used; i++)
                if (hit < 0 && table_copy[i].id == id)
                    hit = i;
            if (hit >= 0)
            begin
                v.slot = hit[2:0];
                if (sq > table_copy[hit].seq)
                begin
                    v.lost = sq - table_copy[hit].seq - 16'd1;
                    table_copy[hit] = '{id, sq, pr, pl, now};
                    pkt_total++;
                    v.status = ST_UPDATED;
                end
                else if (sq == table_copy[hit].seq)
                    v.status = ST_DUP;
                else
                    v.status = ST_OLD;
            end
            else if (used < DEPTH)
            begin
                v.slot = used[2:0];
                table_copy[used] = '{id, sq, pr, pl, now};
                used++;
                pkt_total++;
                v.status = ST_NEW;
            end
            else
            begin
                // Lowest priority loses; among equals the oldest, first one winning.
                best = 0;
                best_pr = 256;
                best_age = '0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    age = now - table_copy[i].stamp;
                    if (table_copy[i].prio < best_pr ||
                        (table_copy[i].prio == best_pr && age > best_age))
                    begin
                        best = i;
                        best_pr = table_copy[i].prio;
                        best_age = age;
                    end
                end
                v.evicted = table_copy[best].id;
                v.slot = best[2:0];
                table_copy[best] = '{id, sq, pr, pl, now};
                v.status = ST_REPLACE;
            end
        end
        v.active = used[3:0];
        v.total = pkt_total;
        return v;
    endfunction

    // Track transfers on all three ports.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            used = 0;
            pkt_total = '0;
            age_limit = MAX_AGE_RESET;
            verdict_q.delete();
            fail_count = 0;
            result_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                age_limit = cfg_data;
            if (in_valid && !in_stall)
                verdict_q.push_back(apply_request(req_type, node_id, seq_num,
                                                  priority_req, payload, now_time));
            if (out_valid && !out_stall)
            begin
                got = '{status, slot, lost_count, evicted_id, removed_count,
                        active_count, packets_total};
                result_count++;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: mismatch expected st=%0d slot=%0d lost=%0d ev=%0d rm=%0d act=%0d tot=%0d",
                                 $time, want.status, want.slot, want.lost, want.evicted,
                                 want.removed, want.active, want.total);
                        $display("%0t:          actual   st=%0d slot=%0d lost=%0d ev=%0d rm=%0d act=%0d tot=%0d",
                                 $time, got.status, got.slot, got.lost, got.evicted,
                                 got.removed, got.active, got.total);
                        fail_count++;
                    end
                end
            end
            pending = verdict_q.size();
        end
    end
endmodule

// ----- sim/tb_node_table_dedup_evict.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_node_table_dedup_evict: testbench for the node table
// Drives directed and random packet and cleanup requests with random gaps
// and result stalls, and several max_age settings written while idle.
// ----------------------------------------------------------------------------
module tb_node_table_dedup_evict;
    import ntde_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [15:0] node_id;
    logic [15:0] seq_num;
    logic [7:0]  priority_req;
    logic [31:0] payload;
    logic [31:0] now_time;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] lost_count;
    logic [15:0] evicted_id;
    logic [3:0]  removed_count;
    logic [3:0]  active_count;
    logic [31:0] packets_total;
    int          fail_count;
    int          pending;
    int          result_count;
    int          sent_count;
    int          cleanup_count;
    logic [31:0] clock_ms;
    logic        long_hold;
    logic        stim_done;
    logic [15:0] id_pool [8];
    logic [15:0] seq_pool [8];

    node_table_dedup_evict u_top (.*);

    node_table_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Send one request; it holds until the transfer.
    task automatic send_req(logic rt, logic [15:0] id, logic [15:0] sq, logic [7:0] pr,
                            logic [31:0] pl, logic [31:0] now);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        req_type = rt;
        node_id = id;
        seq_num = sq;
        priority_req = pr;
        payload = pl;
        now_time = now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        if (rt == REQ_CLEANUP)
            cleanup_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every result is back and the block has settled.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_age(logic [31:0] value);
        cfg_we = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // A mostly well-formed random packet on a small pool of nodes.
    task automatic random_packet();
        int k;
        logic [15:0] sq;
        k = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0: sq = seq_pool[k];
            1: sq = seq_pool[k] - 16'($urandom_range(1, 5));
            2: sq = 16'($urandom);
            default: sq = seq_pool[k] + 16'($urandom_range(1, 4));
        endcase
        if (sq > seq_pool[k])
            seq_pool[k] = sq;
        if ($urandom_range(0, 7) == 0)
            id_pool[k] = 16'($urandom);
        clock_ms = clock_ms + $urandom_range(0, 4000);
        send_req(REQ_PACKET, id_pool[k], sq, 8'($urandom), $urandom, clock_ms);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            out_stall = 1'b0;
            if (out_valid)
            begin
                @(posedge clk);
                @(negedge clk);
                wait_n = $urandom_range(0, 12);
                if (stim_done || $urandom_range(0, 3) == 0)
                    wait_n = 0;
                if (wait_n != 0)
                begin
                    out_stall = 1'b1;
                    repeat (wait_n - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        logic [31:0] ages [4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_PACKET;
        node_id = '0;
        seq_num = '0;
        priority_req = '0;
        payload = '0;
        now_time = '0;
        sent_count = 0;
        cleanup_count = 0;
        clock_ms = 32'hFFFF_0000;
        long_hold = 1'b0;
        stim_done = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            id_pool[i] = 16'h100 + 16'(i);
            seq_pool[i] = 16'd10;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: cleanup on empty table, extremes, dup, old, update, full, evict.
        send_req(REQ_CLEANUP, 16'hFFFF, 16'hFFFF, 8'hFF, '1, '0);
        send_req(REQ_PACKET, 16'h0000, 16'h0000, 8'h00, '0, 32'h0000_0000);
        send_req(REQ_PACKET, 16'hFFFF, 16'hFFFF, 8'hFF, '1, 32'hFFFF_FFFF);
        send_req(REQ_PACKET, 16'h0000, 16'hFFFF, 8'hFF, '1, 32'h0000_0010);
        send_req(REQ_PACKET, 16'h0000, 16'hFFFF, 8'h10, 32'h5A5A, 32'h0000_0020);
        send_req(REQ_PACKET, 16'h0000, 16'h0001, 8'h10, 32'h5A5A, 32'h0000_0030);
        for (int i = 0; i < 7; i++)
            send_req(REQ_PACKET, 16'h200 + 16'(i), 16'(i), 8'h40 + 8'(i % 3), $urandom,
                     32'h100 * 32'(i));
        send_req(REQ_PACKET, 16'h0300, 16'd5, 8'h80, $urandom, 32'h1000);
        send_req(REQ_PACKET, 16'h0301, 16'd5, 8'h00, $urandom, 32'h1000);
        send_req(REQ_PACKET, 16'h0302, 16'd5, 8'h00, $urandom, 32'h2000);
        send_req(REQ_CLEANUP, '0, '0, '0, '0, 32'h0000_1000);
        drain();
        write_age(32'd0);
        send_req(REQ_CLEANUP, '0, '0, '0, '0, 32'h0000_1000);
        drain();
        write_age(32'hFFFF_FFFF);
        send_req(REQ_CLEANUP, '0, '0, '0, '0, 32'h8000_0000);

        // Long receiver hold-off while requests keep coming.
        long_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            random_packet();

        // Random phases with different age limits.
        ages = '{32'd5000, 32'd1800000, 32'd20000, 32'hFFFF_FFFF};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_age(ages[p]);
            for (int n = 0; n < 145; n++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_req(REQ_CLEANUP, 16'($urandom), 16'($urandom), 8'($urandom),
                             $urandom, clock_ms + $urandom_range(0, 30000));
                else
                    random_packet();
            end
        end
        stim_done = 1'b1;
        drain();
        $display("Sent %0d requests (%0d cleanups), checked %0d results.",
                 sent_count, cleanup_count, result_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/ntde_pkg.sv
design/ntde_cell.sv
design/node_table_dedup_evict.sv
sim/node_table_checker.sv
sim/tb_node_table_dedup_evict.sv
